// ===== rtl/mrws_pkg.sv =====
// ----------------------------------------------------------------------------
// mrws_pkg
// shared types, control store and constants of the masked ring smoother
// ----------------------------------------------------------------------------
package mrws_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSmooth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGridW   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGridH   = 2'd2;
  localparam int CfgDataW = 7;

  // fixed field widths
  localparam int ZW     = 16;
  localparam int OutW   = 24;
  localparam int WsOutW = 10;
  localparam int FracW  = 8;
  localparam longint OutMax = 64'd8388607;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ACCEPT,
    OP_INIT,
    OP_RING,
    OP_WALK,
    OP_DIV_LOAD,
    OP_DIV_WAIT,
    OP_PUSH
  } op_e;

  // jump conditions
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_CLR_MORE,
    COND_NO_BEAT,
    COND_WRITE,
    COND_RING_DONE,
    COND_WALK_MORE,
    COND_DIV_BUSY,
    COND_OUT_STALL
  } cond_e;

  localparam int PcW = 4;
  typedef logic [PcW-1:0] pc_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } uword_t;

  // status flags from the datapath to the sequencer
  typedef struct packed {
    logic clr_last;
    logic beat;
    logic is_write;
    logic ring_done;
    logic walk_last;
    logic div_busy;
    logic out_stall;
  } status_t;

  // program steps
  localparam pc_t PcClear   = 4'd0;
  localparam pc_t PcWait    = 4'd1;
  localparam pc_t PcInit    = 4'd2;
  localparam pc_t PcRing    = 4'd3;
  localparam pc_t PcWalk    = 4'd4;
  localparam pc_t PcLoop    = 4'd5;
  localparam pc_t PcDivLoad = 4'd6;
  localparam pc_t PcDivWait = 4'd7;
  localparam pc_t PcPush    = 4'd8;
  localparam pc_t PcBack    = 4'd9;

  // control store
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      PcClear:   w = '{op: OP_CLEAR,    cond: COND_CLR_MORE,  target: PcClear};
      PcWait:    w = '{op: OP_ACCEPT,   cond: COND_NO_BEAT,   target: PcWait};
      PcInit:    w = '{op: OP_INIT,     cond: COND_WRITE,     target: PcWait};
      PcRing:    w = '{op: OP_RING,     cond: COND_RING_DONE, target: PcDivLoad};
      PcWalk:    w = '{op: OP_WALK,     cond: COND_WALK_MORE, target: PcWalk};
      PcLoop:    w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: PcRing};
      PcDivLoad: w = '{op: OP_DIV_LOAD, cond: COND_NEVER,     target: PcWait};
      PcDivWait: w = '{op: OP_DIV_WAIT, cond: COND_DIV_BUSY,  target: PcDivWait};
      PcPush:    w = '{op: OP_PUSH,     cond: COND_OUT_STALL, target: PcPush};
      PcBack:    w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: PcWait};
      default:   w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: PcWait};
    endcase
    return w;
  endfunction

  // largest weight sum for a given ring count
  function automatic int wsum_max(int s);
    int acc;
    acc = s + 1;
    for (int i = 1; i <= s; i++) begin
      acc = acc + 8 * i * (s - i + 1);
    end
    return acc;
  endfunction

endpackage

// ===== rtl/mrws_seq.sv =====
// ----------------------------------------------------------------------------
// mrws_seq
// step counter over the control store with conditional jumps
// ----------------------------------------------------------------------------
module mrws_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrws_pkg::status_t st_i,
  output mrws_pkg::op_e     op_o
);

  mrws_pkg::pc_t    pc_q, pc_d;
  mrws_pkg::uword_t uw;
  logic             take;

  always_comb begin
    uw = mrws_pkg::ucode(pc_q);
    unique case (uw.cond)
      mrws_pkg::COND_NEVER:     take = 1'b0;
      mrws_pkg::COND_ALWAYS:    take = 1'b1;
      mrws_pkg::COND_CLR_MORE:  take = !st_i.clr_last;
      mrws_pkg::COND_NO_BEAT:   take = !st_i.beat;
      mrws_pkg::COND_WRITE:     take = st_i.is_write;
      mrws_pkg::COND_RING_DONE: take = st_i.ring_done;
      mrws_pkg::COND_WALK_MORE: take = !st_i.walk_last;
      mrws_pkg::COND_DIV_BUSY:  take = st_i.div_busy;
      mrws_pkg::COND_OUT_STALL: take = st_i.out_stall;
      default:                  take = 1'b0;
    endcase
    pc_d = take ? uw.target : pc_q + 1'b1;
    op_o = uw.op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= mrws_pkg::PcClear;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/mrws_div.sv =====
// ----------------------------------------------------------------------------
// mrws_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mrws_div #(
  parameter int NW = 34,
  parameter int DW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quo_o
);

  localparam int CntW = $clog2(NW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   den_q, den_d;
  logic [DW:0]     trial, diff;
  logic            ge;

  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = CntW'(NW);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[NW-2:0], ge};
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule

// ===== rtl/masked_ring_weighted_smoother.sv =====
// ----------------------------------------------------------------------------
// masked_ring_weighted_smoother
// masked weighted average of a depth cell grid around a query point
// ----------------------------------------------------------------------------
// usage
//   s_axis: one beat per request. tuser[0] selects write (0) or query (1);
//   a write stores a depth cell (tuser[1] = present) or marks it empty, a
//   query asks for the weighted average around (x, y) with centre value z.
//   m_axis: one beat per query, none per write.
//   cfg: plain write port, index 0 smoothing factor, 1 grid width,
//   2 grid height; write only while no request is in flight.
// timing
//   after reset the store is swept clear, cell by cell, with tready
//   low; configuration writes are taken during the sweep.
//   a write passes through the init step from beat to the next tready.
//   in a query with s rings the ring walk reads one cell per cycle from
//   the single read port of the store, and the divider retires one
//   quotient bit per cycle of its NW-bit dividend (NW is 34 at the
//   default parameters).
// stall
//   the result waits in the output register; a stalled receiver holds the
//   program on the push step until the register frees up.
// ----------------------------------------------------------------------------
module masked_ring_weighted_smoother #(
  parameter int GRID_DIM   = 64,
  parameter int MAX_SMOOTH = 7,
  parameter int DEPTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_coord, y_coord, depth_value, pad
  input  logic [1:0]  s_axis_tuser,   // req_type, cell_present
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // smoothed_value, weight_sum, pad
);

  // derived sizes
  localparam int SW    = $clog2(MAX_SMOOTH + 1);
  localparam int WMAX  = mrws_pkg::wsum_max(MAX_SMOOTH);
  localparam int WSW   = $clog2(WMAX + 1);
  localparam int VW    = (DEPTH_BITS > mrws_pkg::ZW) ? DEPTH_BITS : mrws_pkg::ZW;
  localparam int TW    = VW + WSW + 1;
  localparam int NW    = TW - 1 + mrws_pkg::FracW;
  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(GRID_DIM);
  localparam int CB    = ($clog2(GRID_DIM + 1) > 7) ? $clog2(GRID_DIM + 1) : 7;
  localparam int CW    = CB + 2;
  localparam int OW    = mrws_pkg::OutW;

  // sequencer
  mrws_pkg::op_e     op;
  mrws_pkg::status_t st;

  mrws_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .op_o   (op)
  );

  // configuration
  logic [2:0] smooth_q;
  logic [6:0] gw_q, gh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= 3'd0;
      gw_q     <= 7'd64;
      gh_q     <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mrws_pkg::CfgSmooth: smooth_q <= cfg_wdata_i[2:0];
        mrws_pkg::CfgGridW:  gw_q     <= cfg_wdata_i;
        mrws_pkg::CfgGridH:  gh_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // saturated settings
  logic [SW-1:0]   s_eff;
  logic [SW:0]     s_plus1;
  logic signed [CW-1:0] w_eff, h_eff;

  assign s_eff   = (32'(smooth_q) > MAX_SMOOTH) ? SW'(MAX_SMOOTH) : SW'(smooth_q);
  assign s_plus1 = (SW + 1)'(s_eff) + 1'b1;
  assign w_eff   = (32'(gw_q) > GRID_DIM) ? CW'(GRID_DIM) : CW'(gw_q);
  assign h_eff   = (32'(gh_q) > GRID_DIM) ? CW'(GRID_DIM) : CW'(gh_q);

  // input beat fields
  logic        beat;
  logic        in_req, in_pres;
  logic [5:0]  in_x, in_y;
  logic signed [mrws_pkg::ZW-1:0] in_z;
  logic [CW-1:0] in_xw, in_yw;
  logic        in_wr;

  assign s_axis_tready = (op == mrws_pkg::OP_ACCEPT);
  assign beat    = s_axis_tvalid && s_axis_tready;
  assign in_req  = s_axis_tuser[0];
  assign in_pres = s_axis_tuser[1];
  assign in_x    = s_axis_tdata[5:0];
  assign in_y    = s_axis_tdata[11:6];
  assign in_z    = s_axis_tdata[27:12];
  assign in_xw   = CW'(in_x);
  assign in_yw   = CW'(in_y);
  // writes beyond the store are dropped
  assign in_wr   = beat && !in_req && (32'(in_x) < GRID_DIM) && (32'(in_y) < GRID_DIM);

  // latched request
  logic        req_q;
  logic [5:0]  x_q, y_q;
  logic signed [mrws_pkg::ZW-1:0] z_q;

  always_ff @(posedge clk_i) begin
    if (beat) begin
      req_q <= in_req;
      x_q   <= in_x;
      y_q   <= in_y;
      z_q   <= in_z;
    end
  end

  // depth store: present flag on top of the value
  logic [DEPTH_BITS:0] mem [DEPTH];
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [DEPTH_BITS:0] mem_wd;
  logic [AW-1:0]       rd_addr;
  logic                rd_en;
  logic [DEPTH_BITS:0] rd_data_q;
  logic signed [DEPTH_BITS-1:0] wr_val;
  logic [AW-1:0]       clr_cnt_q;

  assign wr_val = DEPTH_BITS'(in_z);

  always_comb begin
    if (op == mrws_pkg::OP_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q;
      mem_wd = '0;
    end else begin
      mem_we = in_wr;
      mem_wa = AW'(in_yw[IW-1:0]) * AW'(GRID_DIM) + AW'(in_xw[IW-1:0]);
      mem_wd = in_pres ? {1'b1, wr_val} : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // ring walk state
  logic [SW-1:0]   ring_q, ring_d, ring_nx;
  logic [1:0]      leg_q, leg_d;
  logic [SW:0]     pos_q, pos_d, pos_last;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic            in_grid;
  logic [SW:0]     wt_full;

  assign ring_nx  = ring_q + 1'b1;
  assign pos_last = {ring_q, 1'b0} - 1'b1;
  assign in_grid  = (cx_q >= 0) && (cy_q >= 0) && (cx_q < w_eff) && (cy_q < h_eff);
  assign rd_en    = (op == mrws_pkg::OP_WALK) && in_grid;
  assign rd_addr  = AW'(cy_q[IW-1:0]) * AW'(GRID_DIM) + AW'(cx_q[IW-1:0]);
  assign wt_full  = (SW + 1)'(s_eff) - (SW + 1)'(ring_q) + 1'b1;

  // accumulation
  logic signed [TW-1:0]  total_q, total_d;
  logic [WSW-1:0]        wsum_q, wsum_d;
  logic                  rd_vld_q;
  logic [SW-1:0]         rd_wt_q;
  logic signed [DEPTH_BITS+SW:0] cell_prod;
  logic signed [mrws_pkg::ZW+SW:0] z_prod;

  assign cell_prod = $signed(rd_data_q[DEPTH_BITS-1:0]) * $signed({1'b0, rd_wt_q});
  assign z_prod    = z_q * $signed({1'b0, s_plus1});

  always_comb begin
    ring_d  = ring_q;
    leg_d   = leg_q;
    pos_d   = pos_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    total_d = total_q;
    wsum_d  = wsum_q;
    case (op)
      mrws_pkg::OP_INIT: begin
        total_d = TW'(z_prod);
        wsum_d  = WSW'(s_plus1);
        ring_d  = '0;
      end
      mrws_pkg::OP_RING: begin
        // start at the top left corner of the next ring
        ring_d = ring_nx;
        leg_d  = 2'd0;
        pos_d  = '0;
        cx_d   = $signed(CW'(x_q)) - $signed(CW'(ring_nx));
        cy_d   = $signed(CW'(y_q)) - $signed(CW'(ring_nx));
      end
      mrws_pkg::OP_WALK: begin
        // right, down, left, up along the ring
        case (leg_q)
          2'd0:    cx_d = cx_q + 1'b1;
          2'd1:    cy_d = cy_q + 1'b1;
          2'd2:    cx_d = cx_q - 1'b1;
          default: cy_d = cy_q - 1'b1;
        endcase
        if (pos_q == pos_last) begin
          pos_d = '0;
          leg_d = leg_q + 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      default: ;
    endcase
    // in the cycle after the store read
    if (rd_vld_q && rd_data_q[DEPTH_BITS]) begin
      total_d = total_q + TW'(cell_prod);
      wsum_d  = wsum_q + WSW'(rd_wt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    ring_q  <= ring_d;
    leg_q   <= leg_d;
    pos_q   <= pos_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    total_q <= total_d;
    wsum_q  <= wsum_d;
    rd_wt_q <= wt_full[SW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      rd_vld_q <= rd_en;
      if (op == mrws_pkg::OP_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // division of the scaled magnitude by the weight sum
  logic [TW-1:0] tmag;
  logic [NW-1:0] div_num, quo;
  logic          div_start, div_busy;
  logic          neg_q;

  assign tmag      = total_q[TW-1] ? -total_q : total_q;
  assign div_num   = {tmag[TW-2:0], {mrws_pkg::FracW{1'b0}}};
  assign div_start = (op == mrws_pkg::OP_DIV_LOAD);

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      neg_q <= total_q[TW-1];
    end
  end

  mrws_div #(
    .NW (NW),
    .DW (WSW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (wsum_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // sign and saturation
  logic [OW-1:0] sat_val;

  always_comb begin
    if (!neg_q) begin
      sat_val = (quo > NW'(mrws_pkg::OutMax)) ? {1'b0, {(OW-1){1'b1}}} : quo[OW-1:0];
    end else begin
      sat_val = (quo > NW'(mrws_pkg::OutMax + 1)) ? {1'b1, {(OW-1){1'b0}}}
                                                    : -quo[OW-1:0];
    end
  end

  // output register
  logic                        m_vld_q;
  logic [OW-1:0]               sv_q;
  logic [mrws_pkg::WsOutW-1:0] ws_q;
  logic                        out_stall, push;

  assign out_stall = m_vld_q && !m_axis_tready;
  assign push      = (op == mrws_pkg::OP_PUSH) && !out_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (push) begin
      m_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      sv_q <= sat_val;
      ws_q <= mrws_pkg::WsOutW'(wsum_q);
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {6'd0, ws_q, sv_q};

  // status to the sequencer
  assign st.clr_last  = clr_cnt_q == AW'(DEPTH - 1);
  assign st.beat      = beat;
  assign st.is_write  = !req_q;
  assign st.ring_done = ring_q == s_eff;
  assign st.walk_last = (leg_q == 2'd3) && (pos_q == pos_last);
  assign st.div_busy  = div_busy;
  assign st.out_stall = out_stall;

  // checks
  a_ready_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_busy)
    else $error("request taken while divider busy");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> wsum_q != '0)
    else $error("divider started with zero weight sum");

  a_read_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(op == mrws_pkg::OP_WALK))
    else $error("store read outside ring walk");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> op == mrws_pkg::OP_DIV_WAIT)
    else $error("divider busy outside its wait step");

endmodule

// ===== bench/tb_masked_ring_weighted_smoother.sv =====
// ----------------------------------------------------------------------------
// tb_masked_ring_weighted_smoother
// self-checking bench for the masked ring smoother: directed edge cases, a
// full neighborhood at the largest ring count, output back-pressure and
// random patches of cell writes followed by queries, all predicted in-bench
// ----------------------------------------------------------------------------
module tb_masked_ring_weighted_smoother;

  // bench sizing
  localparam int GridDim      = 64;
  localparam int GridCells    = GridDim * GridDim;
  localparam int SettleCycles = 6;        // margin for a last write to retire
  localparam int TailCycles   = 400;      // longest query plus margin
  localparam int HoldCycles   = 1500;     // long receiver hold-off
  localparam int CycleLimit   = 2000000;  // sweep plus worst-case items, padded

  // request kinds on tuser[0]
  localparam bit ReqWrite = 1'b0;
  localparam bit ReqQuery = 1'b1;

  // expected result of one query
  typedef struct {
    logic signed [mrws_pkg::OutW-1:0] avg;
    logic [mrws_pkg::WsOutW-1:0]      wsum;
  } avg_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [6:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // x_coord, y_coord, depth_value, pad
  logic [1:0]  s_axis_tuser;   // req_type, cell_present
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // smoothed_value, weight_sum, pad

  masked_ring_weighted_smoother dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // bench copy of the cell store and the control registers
  logic signed [mrws_pkg::ZW-1:0] grid_depth [GridCells];
  bit                             grid_full  [GridCells];
  int                             smooth_cfg;
  int                             grid_w_cfg;
  int                             grid_h_cfg;

  avg_result_t avg_expect_q[$];
  int          err_cnt;
  int unsigned cycle_cnt;

  // sender burst state
  bit tx_gaps_on;
  int tx_burst_left;

  // receiver stall pattern and hold-off handshake between processes
  int hold_req_cnt;
  int hold_ack_cnt;
  int hold_left;
  int rx_mode;
  int rx_mode_left;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // weighted average around (cx, cy): centre z weighted s+1, ring i weighted s-i+1
  function automatic avg_result_t predict_ring_average(
      input logic signed [mrws_pkg::ZW-1:0] z,
      input logic [5:0] cx,
      input logic [5:0] cy);
    avg_result_t res;
    int          s, w, h, wt, px, py, idx;
    longint      total, wsum, q;
    s = smooth_cfg;
    w = (grid_w_cfg > GridDim) ? GridDim : grid_w_cfg;
    h = (grid_h_cfg > GridDim) ? GridDim : grid_h_cfg;
    total = longint'(z) * (s + 1);
    wsum  = s + 1;
    for (int i = 1; i <= s; i++) begin
      wt = s - i + 1;
      for (int dy = -i; dy <= i; dy++) begin
        for (int dx = -i; dx <= i; dx++) begin
          // only the square ring itself, not its interior
          if (dx != -i && dx != i && dy != -i && dy != i) continue;
          px = int'(cx) + dx;
          py = int'(cy) + dy;
          if (px < 0 || py < 0 || px >= w || py >= h) continue;
          idx = py * GridDim + px;
          if (!grid_full[idx]) continue;
          total += longint'(grid_depth[idx]) * wt;
          wsum  += wt;
        end
      end
    end
    // longint division truncates toward zero
    q = (total * 256) / wsum;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    res.avg  = q[mrws_pkg::OutW-1:0];
    res.wsum = wsum[mrws_pkg::WsOutW-1:0];
    return res;
  endfunction

  // input monitor: apply writes to the bench store, queue predictions for queries
  always @(posedge clk_i) begin
    logic [5:0]                     bx, by;
    logic signed [mrws_pkg::ZW-1:0] bz;
    if (s_axis_tvalid && s_axis_tready) begin
      bx = s_axis_tdata[5:0];
      by = s_axis_tdata[11:6];
      bz = s_axis_tdata[27:12];
      if (s_axis_tuser[0] == ReqWrite) begin
        grid_full[int'(by) * GridDim + int'(bx)]  = s_axis_tuser[1];
        grid_depth[int'(by) * GridDim + int'(bx)] = s_axis_tuser[1] ? bz : '0;
      end else begin
        avg_expect_q.insert(avg_expect_q.size(), predict_ring_average(bz, bx, by));
      end
    end
  end

  // result checker: each result beat against the oldest prediction
  always @(posedge clk_i) begin
    avg_result_t exp_res;
    if (m_axis_tvalid && m_axis_tready) begin
      if (avg_expect_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, avg %0d wsum %0d", $time,
                 $signed(m_axis_tdata[23:0]), m_axis_tdata[33:24]);
        err_cnt++;
      end else begin
        exp_res = avg_expect_q.pop_front();
        if (m_axis_tdata[23:0] !== exp_res.avg) begin
          $display("%0t: smoothed_value mismatch, expected %0d, actual %0d", $time,
                   exp_res.avg, $signed(m_axis_tdata[23:0]));
          err_cnt++;
        end
        if (m_axis_tdata[33:24] !== exp_res.wsum) begin
          $display("%0t: weight_sum mismatch, expected %0d, actual %0d", $time,
                   exp_res.wsum, m_axis_tdata[33:24]);
          err_cnt++;
        end
      end
    end
  end

  // receiver: long hold-off on request, else a stall pattern that changes over time
  always @(posedge clk_i) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt  <= hold_req_cnt;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(8, 64);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: m_axis_tready <= 1'b1;                           // always ready
        1: m_axis_tready <= 1'($urandom_range(0, 1));       // coin flip
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);    // mostly stalled
        default: m_axis_tready <= ((rx_mode_left % 8) < 5); // periodic stall
      endcase
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one beat on the request stream, with random gaps between bursts when tx_gaps_on is set
  task automatic send_req(input bit is_query, input logic [5:0] x, input logic [5:0] y,
                          input logic signed [mrws_pkg::ZW-1:0] depth, input bit present);
    int gap;
    if (tx_gaps_on && tx_burst_left == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      tx_burst_left = $urandom_range(1, 24);
    end
    if (tx_burst_left > 0) tx_burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, depth, y, x};
    s_axis_tuser  <= {present, is_query};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // sender pause: drop valid and wait until every result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    // let the monitor book the last accepted beat first
    @(posedge clk_i);
    while (avg_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write all three registers on back-to-back cycles; block must be idle
  task automatic set_config(input int s, input int w, input int h);
    int vals [3];
    vals = '{s, w, h};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= (i == 0) ? mrws_pkg::CfgSmooth :
                     (i == 1) ? mrws_pkg::CfgGridW : mrws_pkg::CfgGridH;
      cfg_wdata_i <= vals[i][6:0];
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    smooth_cfg = s & 7;
    grid_w_cfg = w & 127;
    grid_h_cfg = h & 127;
  endtask

  // reset registers: s = 0 hands z straight back, store starts empty
  task automatic test_reset_passthrough();
    send_req(ReqQuery, 6'd0, 6'd0, 16'sh7fff, 1'b0);
    send_req(ReqQuery, 6'd63, 6'd63, -16'sh8000, 1'b1);
    drain_results();
  endtask

  // grid corners, extreme depths, clearing a cell with present low
  task automatic test_ring_edges();
    set_config(7, 64, 64);
    send_req(ReqWrite, 6'd0, 6'd0, 16'sh7fff, 1'b1);
    send_req(ReqWrite, 6'd1, 6'd1, -16'sh8000, 1'b1);
    send_req(ReqWrite, 6'd63, 6'd63, 16'sh7fff, 1'b1);
    send_req(ReqWrite, 6'd62, 6'd62, -16'sh0001, 1'b1);
    send_req(ReqQuery, 6'd62, 6'd63, 16'sh0000, 1'b0);
    send_req(ReqWrite, 6'd62, 6'd62, 16'sh1234, 1'b0);  // marks the cell empty
    send_req(ReqQuery, 6'd0, 6'd0, 16'sh0000, 1'b0);
    send_req(ReqQuery, 6'd63, 6'd63, -16'sh8000, 1'b0);
    send_req(ReqQuery, 6'd7, 6'd7, 16'sh0005, 1'b0);     // (0,0) right on ring 7
    send_req(ReqQuery, 6'd8, 6'd8, -16'sh0005, 1'b0);    // (0,0) just beyond reach
    drain_results();
  endtask

  // active grid smaller than the store, zero and oversized sizes
  task automatic test_grid_bounds();
    set_config(3, 1, 1);
    send_req(ReqWrite, 6'd5, 6'd5, 16'sh0100, 1'b1);     // kept though out of grid
    send_req(ReqQuery, 6'd0, 6'd0, 16'sh0011, 1'b0);
    send_req(ReqQuery, 6'd4, 6'd4, -16'sh0011, 1'b0);    // centre out of grid
    drain_results();
    set_config(3, 0, 100);                               // no ring cell in grid
    send_req(ReqQuery, 6'd4, 6'd4, 16'sh0022, 1'b0);
    drain_results();
    set_config(2, 127, 6);                               // width saturates
    send_req(ReqQuery, 6'd4, 6'd4, 16'sh0033, 1'b0);
    send_req(ReqQuery, 6'd4, 6'd3, 16'sh0033, 1'b0);     // (5,5) on the row limit
    drain_results();
  endtask

  // every ring cell present at s = 7: largest weight sum, both depth extremes
  task automatic test_full_neighborhood();
    logic signed [mrws_pkg::ZW-1:0] fill;
    set_config(7, 64, 64);
    for (int pass = 0; pass < 2; pass++) begin
      fill = (pass == 0) ? 16'sh7fff : -16'sh8000;
      for (int y = 23; y <= 37; y++) begin
        for (int x = 23; x <= 37; x++) begin
          send_req(ReqWrite, x[5:0], y[5:0], fill, 1'b1);
        end
      end
      send_req(ReqQuery, 6'd30, 6'd30, fill, 1'b0);
      send_req(ReqQuery, 6'd23, 6'd37, ~fill, 1'b0);
    end
    drain_results();
  endtask

  // receiver holds off while queries keep coming, so the input side backs up
  task automatic test_output_backpressure();
    set_config(7, 64, 64);
    hold_req_cnt <= hold_req_cnt + 1;
    for (int i = 0; i < 6; i++) begin
      send_req(ReqQuery, 6'($urandom_range(26, 34)), 6'($urandom_range(26, 34)),
               16'($urandom), 1'b0);
    end
    drain_results();
  endtask

  // random depth, mostly uniform, extremes and values near zero now and then
  function automatic logic signed [mrws_pkg::ZW-1:0] rand_depth();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // random grid size register value, extremes and out-of-range included
  function automatic int rand_grid_size();
    case ($urandom_range(0, 9))
      0: return 1;
      1, 2: return 64;
      3: return 0;
      4: return $urandom_range(65, 127);
      5: return $urandom_range(2, 10);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  // patches: cell writes around a window, then queries inside it; some noise
  task automatic test_random_patches(input int n_items);
    int sent, bx, by, n_wr, n_q, s;
    int px, py;
    sent = 0;
    while (sent < n_items) begin
      drain_results();
      s = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 1) ? 7 : 0)
                                      : $urandom_range(0, 7);
      set_config(s, rand_grid_size(), rand_grid_size());
      tx_gaps_on = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < 90 && sent < n_items; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          // window near the low corner, the high corner, or anywhere
          case ($urandom_range(0, 2))
            0: begin bx = 0;                     by = 0;                     end
            1: begin bx = 48;                    by = 48;                    end
            default: begin bx = $urandom_range(0, 48); by = $urandom_range(0, 48); end
          endcase
          n_wr = $urandom_range(3, 10);
          n_q  = $urandom_range(1, 3);
          for (int j = 0; j < n_wr; j++) begin
            px = bx + $urandom_range(0, 15);
            py = by + $urandom_range(0, 15);
            send_req(ReqWrite, px[5:0], py[5:0], rand_depth(), $urandom_range(0, 7) != 0);
          end
          for (int j = 0; j < n_q; j++) begin
            px = bx + $urandom_range(0, 15);
            py = by + $urandom_range(0, 15);
            send_req(ReqQuery, px[5:0], py[5:0], rand_depth(), 1'($urandom_range(0, 1)));
          end
          sent += n_wr + n_q;
        end else begin
          send_req(1'($urandom_range(0, 1)), 6'($urandom), 6'($urandom), 16'($urandom),
                   1'($urandom_range(0, 1)));
          sent++;
        end
        // occasional pause until the pipeline is empty
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end
    drain_results();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = mrws_pkg::CfgSmooth;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    hold_req_cnt  = 0;
    hold_ack_cnt  = 0;
    hold_left     = 0;
    rx_mode       = 0;
    rx_mode_left  = 0;
    tx_gaps_on    = 1'b0;
    tx_burst_left = 0;
    smooth_cfg    = 0;
    grid_w_cfg    = 64;
    grid_h_cfg    = 64;
    for (int i = 0; i < GridCells; i++) begin
      grid_depth[i] = '0;
      grid_full[i]  = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // the clearing sweep holds tready low; sends simply wait it out
    test_reset_passthrough();
    test_ring_edges();
    test_grid_bounds();
    test_full_neighborhood();
    test_output_backpressure();
    test_random_patches(600);
    tx_gaps_on = 1'b1;
    test_output_backpressure();

    // quiet tail so a stray result still gets caught
    s_axis_tvalid <= 1'b0;
    while (avg_expect_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0 && avg_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== masked_ring_weighted_smoother.f =====
rtl/mrws_pkg.sv
rtl/mrws_seq.sv
rtl/mrws_div.sv
rtl/masked_ring_weighted_smoother.sv
bench/tb_masked_ring_weighted_smoother.sv
